/* sv/lt_pkg.sv */
// Package with shared types and constants of the lease table.
package lt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TTL_W = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [FUNC_W-1:0] {
    FN_ACQUIRE = 3'd0,
    FN_RELEASE = 3'd1,
    FN_PRUNE = 3'd2,
    FN_DROP = 3'd3,
    FN_FIND = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED = 4'd0,
    ST_RENEWED = 4'd1,
    ST_REJECTED = 4'd2,
    ST_RELEASED = 4'd3,
    ST_NOT_RELEASED = 4'd4,
    ST_FOUND = 4'd5,
    ST_ABSENT = 4'd6,
    ST_COUNT = 4'd7,
    ST_FULL = 4'd8
  } status_e;

  // One request as it travels from the front end to the back end.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0] lease_key;
    logic [KEY_W-1:0] holder;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] holder_address;
    logic [TIME_W-1:0] now_ms;
  } req_t;

endpackage

/* sv/lt_front.sv */
// Front end: accepts requests, computes the saturated expiry, feeds a queue.
module lt_front #(
  parameter int unsigned DEPTH = lt_pkg::QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [lt_pkg::FUNC_W-1:0] func_i,
  input  logic [lt_pkg::KEY_W-1:0] lease_key_i,
  input  logic [lt_pkg::KEY_W-1:0] holder_i,
  input  logic [lt_pkg::TTL_W-1:0] ttl_i,
  input  logic [lt_pkg::TIME_W-1:0] holder_address_i,
  input  logic [lt_pkg::TIME_W-1:0] now_ms_i,
  output logic req_valid_o,
  input  logic req_pop_i,
  output lt_pkg::req_t req_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lt_pkg::req_t fifo_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0] cnt_q, cnt_d;
  logic push;
  logic [lt_pkg::TIME_W:0] sum;
  lt_pkg::req_t req_in;

  assign in_stall_o = (cnt_q == (PW+1)'(DEPTH));
  assign push = in_valid_i && !in_stall_o;
  assign sum = {1'b0, now_ms_i} + (lt_pkg::TIME_W+1)'(ttl_i);

  always_comb begin
    req_in.func = func_i;
    req_in.lease_key = lease_key_i;
    req_in.holder = holder_i;
    req_in.expiry = sum[lt_pkg::TIME_W] ? '1 : sum[lt_pkg::TIME_W-1:0];
    req_in.holder_address = holder_address_i;
    req_in.now_ms = now_ms_i;
  end

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (req_pop_i) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(req_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= req_in;
    end
  end

  assign req_valid_o = (cnt_q != '0);
  assign req_o = fifo_q[rd_q];
endmodule

/* sv/lt_back.sv */
// Back end: walks the table one entry per cycle and writes one result.
module lt_back #(
  parameter int unsigned ENTRIES = lt_pkg::ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_pop_o,
  input  lt_pkg::req_t req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [lt_pkg::STATUS_W-1:0] status_o,
  output logic [lt_pkg::KEY_W-1:0] current_holder_o,
  output logic [lt_pkg::TIME_W-1:0] remaining_ms_o,
  output logic [lt_pkg::TIME_W-1:0] entry_expiry_o,
  output logic [lt_pkg::TIME_W-1:0] entry_address_o,
  output logic [lt_pkg::COUNT_W-1:0] removed_count_o
);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [ENTRIES-1:0] valid_q;
  logic [lt_pkg::KEY_W-1:0] key_q [ENTRIES];
  logic [lt_pkg::KEY_W-1:0] hold_q [ENTRIES];
  logic [lt_pkg::TIME_W-1:0] exp_q [ENTRIES];
  logic [lt_pkg::TIME_W-1:0] addr_q [ENTRIES];

  logic [1:0] st_q;
  logic [IW-1:0] idx_q;
  lt_pkg::req_t r_q;
  logic hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;
  logic [lt_pkg::COUNT_W-1:0] cnt_q;
  logic last;
  logic rm;

  assign last = (idx_q == IW'(ENTRIES-1));
  assign req_pop_o = (st_q == S_IDLE) && req_valid_i;
  assign out_valid_o = (st_q == S_OUT);

  always_comb begin
    rm = 1'b0;
    if (valid_q[idx_q]) begin
      if (r_q.func == lt_pkg::FN_PRUNE) rm = exp_q[idx_q] <= r_q.now_ms;
      else if (r_q.func == lt_pkg::FN_DROP) rm = addr_q[idx_q] == r_q.holder_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      valid_q <= '0;
      idx_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (req_valid_i) begin
            st_q <= S_SCAN;
            idx_q <= '0;
          end
        end
        S_SCAN: begin
          if (rm) valid_q[idx_q] <= 1'b0;
          if (last) st_q <= S_ACT;
          else idx_q <= idx_q + 1'b1;
        end
        S_ACT: begin
          st_q <= S_OUT;
          if (r_q.func == lt_pkg::FN_ACQUIRE && !hit_q && free_q) begin
            valid_q[free_idx_q] <= 1'b1;
          end
          if (r_q.func == lt_pkg::FN_RELEASE && hit_q && hold_q[hit_idx_q] == r_q.holder) begin
            valid_q[hit_idx_q] <= 1'b0;
          end
        end
        S_OUT: begin
          if (!out_stall_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        r_q <= req_i;
        hit_q <= 1'b0;
        free_q <= 1'b0;
        hit_idx_q <= '0;
        free_idx_q <= '0;
        cnt_q <= '0;
      end
      S_SCAN: begin
        if (valid_q[idx_q] && key_q[idx_q] == r_q.lease_key && !hit_q) begin
          hit_q <= 1'b1;
          hit_idx_q <= idx_q;
        end
        if (!valid_q[idx_q] && !free_q) begin
          free_q <= 1'b1;
          free_idx_q <= idx_q;
        end
        if (rm && cnt_q != lt_pkg::COUNT_MAX) cnt_q <= cnt_q + 1'b1;
      end
      S_ACT: begin
        status_o <= lt_pkg::ST_ABSENT;
        current_holder_o <= '0;
        remaining_ms_o <= '0;
        entry_expiry_o <= '0;
        entry_address_o <= '0;
        removed_count_o <= '0;
        case (r_q.func) inside
          lt_pkg::FN_ACQUIRE: begin
            if (!hit_q) begin
              if (free_q) begin
                key_q[free_idx_q] <= r_q.lease_key;
                hold_q[free_idx_q] <= r_q.holder;
                exp_q[free_idx_q] <= r_q.expiry;
                addr_q[free_idx_q] <= r_q.holder_address;
                status_o <= lt_pkg::ST_ACQUIRED;
              end else begin
                status_o <= lt_pkg::ST_FULL;
              end
            end else if (hold_q[hit_idx_q] == r_q.holder ||
                         exp_q[hit_idx_q] <= r_q.now_ms) begin
              hold_q[hit_idx_q] <= r_q.holder;
              exp_q[hit_idx_q] <= r_q.expiry;
              addr_q[hit_idx_q] <= r_q.holder_address;
              status_o <= (hold_q[hit_idx_q] == r_q.holder) ?
                          lt_pkg::ST_RENEWED : lt_pkg::ST_ACQUIRED;
            end else begin
              status_o <= lt_pkg::ST_REJECTED;
              current_holder_o <= hold_q[hit_idx_q];
              remaining_ms_o <= exp_q[hit_idx_q] - r_q.now_ms;
            end
          end
          lt_pkg::FN_RELEASE: begin
            status_o <= (hit_q && hold_q[hit_idx_q] == r_q.holder) ?
                        lt_pkg::ST_RELEASED : lt_pkg::ST_NOT_RELEASED;
          end
          lt_pkg::FN_PRUNE, lt_pkg::FN_DROP: begin
            status_o <= lt_pkg::ST_COUNT;
            removed_count_o <= cnt_q;
          end
          lt_pkg::FN_FIND: begin
            if (hit_q) begin
              status_o <= lt_pkg::ST_FOUND;
              current_holder_o <= hold_q[hit_idx_q];
              entry_expiry_o <= exp_q[hit_idx_q];
              entry_address_o <= addr_q[hit_idx_q];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end
endmodule

/* sv/lease_table_top.sv */
// Top level of the lease table: request queue in front of the table engine.
// The result follows the back end's walk over the table, one entry per cycle; the
// back end starts the next request only after the previous result has been taken.
// The front queue holds two requests, so inputs are still accepted during a walk until it is full.
// Reset (rst_ni low, asynchronous) empties the queue and marks every entry free.
module lease_table_top #(
  parameter int unsigned ENTRIES = lt_pkg::ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [lt_pkg::FUNC_W-1:0] func_i,
  input  logic [lt_pkg::KEY_W-1:0] lease_key_i,
  input  logic [lt_pkg::KEY_W-1:0] holder_i,
  input  logic [lt_pkg::TTL_W-1:0] ttl_i,
  input  logic [lt_pkg::TIME_W-1:0] holder_address_i,
  input  logic [lt_pkg::TIME_W-1:0] now_ms_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [lt_pkg::STATUS_W-1:0] status_o,
  output logic [lt_pkg::KEY_W-1:0] current_holder_o,
  output logic [lt_pkg::TIME_W-1:0] remaining_ms_o,
  output logic [lt_pkg::TIME_W-1:0] entry_expiry_o,
  output logic [lt_pkg::TIME_W-1:0] entry_address_o,
  output logic [lt_pkg::COUNT_W-1:0] removed_count_o
);
  logic req_valid, req_pop;
  lt_pkg::req_t req;

  // The front end stamps each transfer with its saturated expiry time.
  lt_front #(.DEPTH(lt_pkg::QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .lease_key_i,
    .holder_i, .ttl_i, .holder_address_i, .now_ms_i,
    .req_valid_o(req_valid), .req_pop_i(req_pop), .req_o(req)
  );

  // The back end owns the table and produces one result per request.
  lt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_pop_o(req_pop), .req_i(req),
    .out_valid_o, .out_stall_i, .status_o, .current_holder_o, .remaining_ms_o,
    .entry_expiry_o, .entry_address_o, .removed_count_o
  );
endmodule

/* bench/lease_table_top_tb.sv */
// Self-checking testbench for the lease table: random requests checked against a built-in predictor.
module lease_table_top_tb;

  localparam int unsigned NSLOT = lt_pkg::ENTRIES_DEF;
  localparam int unsigned TIMEOUT_CYCLES = 1000000;
  localparam int unsigned KEY_POOL = 20;
  localparam logic [lt_pkg::TIME_W-1:0] TIME_MAX = '1;

  // One request as the sender presents it. The func field is kept as a raw
  // vector so that the undefined codes 5 to 7 can be sent too.
  typedef struct {
    logic [lt_pkg::FUNC_W-1:0] func;
    logic [lt_pkg::KEY_W-1:0] lease_key;
    logic [lt_pkg::KEY_W-1:0] holder;
    logic [lt_pkg::TTL_W-1:0] ttl;
    logic [lt_pkg::TIME_W-1:0] addr;
    logic [lt_pkg::TIME_W-1:0] now_ms;
  } lease_req_t;

  // One answer of the table, field for field as it leaves the block.
  typedef struct {
    logic [lt_pkg::STATUS_W-1:0] status;
    logic [lt_pkg::KEY_W-1:0] cur_holder;
    logic [lt_pkg::TIME_W-1:0] remaining;
    logic [lt_pkg::TIME_W-1:0] expiry;
    logic [lt_pkg::TIME_W-1:0] address;
    logic [lt_pkg::COUNT_W-1:0] removed;
  } lease_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [lt_pkg::FUNC_W-1:0] func_i;
  logic [lt_pkg::KEY_W-1:0] lease_key_i;
  logic [lt_pkg::KEY_W-1:0] holder_i;
  logic [lt_pkg::TTL_W-1:0] ttl_i;
  logic [lt_pkg::TIME_W-1:0] holder_address_i;
  logic [lt_pkg::TIME_W-1:0] now_ms_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [lt_pkg::STATUS_W-1:0] status_o;
  logic [lt_pkg::KEY_W-1:0] current_holder_o;
  logic [lt_pkg::TIME_W-1:0] remaining_ms_o;
  logic [lt_pkg::TIME_W-1:0] entry_expiry_o;
  logic [lt_pkg::TIME_W-1:0] entry_address_o;
  logic [lt_pkg::COUNT_W-1:0] removed_count_o;

  lease_table_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .func_i(func_i),
    .lease_key_i(lease_key_i),
    .holder_i(holder_i),
    .ttl_i(ttl_i),
    .holder_address_i(holder_address_i),
    .now_ms_i(now_ms_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .current_holder_o(current_holder_o),
    .remaining_ms_o(remaining_ms_o),
    .entry_expiry_o(entry_expiry_o),
    .entry_address_o(entry_address_o),
    .removed_count_o(removed_count_o)
  );

  // Requests waiting to be sent, and answers predicted but not yet seen.
  lease_req_t pending_reqs[$];
  lease_res_t expected_answers[$];

  // Shadow copy of the lease table, updated once per accepted request.
  logic slot_used[NSLOT] = '{default: 1'b0};
  logic [lt_pkg::KEY_W-1:0] slot_key[NSLOT];
  logic [lt_pkg::KEY_W-1:0] slot_holder[NSLOT];
  logic [lt_pkg::TIME_W-1:0] slot_expiry[NSLOT];
  logic [lt_pkg::TIME_W-1:0] slot_addr[NSLOT];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned answer_count = 0;
  int unsigned status_seen[16] = '{default: 0};
  bit calm = 1'b0;

  // Pools that make keys, holders and addresses collide often enough to hit
  // renewals, rejections, takeovers and a full table.
  logic [lt_pkg::KEY_W-1:0] key_pool[KEY_POOL];
  logic [lt_pkg::KEY_W-1:0] holder_pool[4];
  logic [lt_pkg::TIME_W-1:0] addr_pool[4];
  logic [lt_pkg::TIME_W-1:0] sim_now;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Idle gaps: mostly none or short, now and then a long one. During calm
  // stretches neither side idles, so the block runs back to back.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Computes the answer to one request and applies its effect on the table.
  function automatic lease_res_t predict_lease(lease_req_t r);
    lease_res_t res;
    logic [lt_pkg::TIME_W:0] sum;
    logic [lt_pkg::TIME_W-1:0] new_exp;
    int hit;
    int free_idx;
    res = '{status: lt_pkg::ST_ABSENT, cur_holder: '0, remaining: '0, expiry: '0,
            address: '0, removed: '0};
    hit = -1;
    free_idx = -1;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == r.lease_key) hit = i;
      if (!slot_used[i]) free_idx = i;
    end
    sum = {1'b0, r.now_ms} + {{(lt_pkg::TIME_W + 1 - lt_pkg::TTL_W){1'b0}}, r.ttl};
    // Expiry saturates at the largest time instead of wrapping.
    new_exp = sum[lt_pkg::TIME_W] ? TIME_MAX : sum[lt_pkg::TIME_W-1:0];
    case (r.func) inside
      lt_pkg::FN_ACQUIRE: begin
        if (hit < 0) begin
          if (free_idx < 0) begin
            res.status = lt_pkg::ST_FULL;
          end else begin
            slot_used[free_idx] = 1'b1;
            slot_key[free_idx] = r.lease_key;
            slot_holder[free_idx] = r.holder;
            slot_expiry[free_idx] = new_exp;
            slot_addr[free_idx] = r.addr;
            res.status = lt_pkg::ST_ACQUIRED;
          end
        end else if (slot_holder[hit] == r.holder || slot_expiry[hit] <= r.now_ms) begin
          res.status = (slot_holder[hit] == r.holder) ? lt_pkg::ST_RENEWED
                                                      : lt_pkg::ST_ACQUIRED;
          slot_holder[hit] = r.holder;
          slot_expiry[hit] = new_exp;
          slot_addr[hit] = r.addr;
        end else begin
          res.status = lt_pkg::ST_REJECTED;
          res.cur_holder = slot_holder[hit];
          res.remaining = slot_expiry[hit] - r.now_ms;
        end
      end
      lt_pkg::FN_RELEASE: begin
        if (hit >= 0 && slot_holder[hit] == r.holder) begin
          slot_used[hit] = 1'b0;
          res.status = lt_pkg::ST_RELEASED;
        end else begin
          res.status = lt_pkg::ST_NOT_RELEASED;
        end
      end
      lt_pkg::FN_PRUNE, lt_pkg::FN_DROP: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_used[i] && (r.func == lt_pkg::FN_PRUNE ? slot_expiry[i] <= r.now_ms
                                                          : slot_addr[i] == r.addr)) begin
            slot_used[i] = 1'b0;
            if (res.removed != lt_pkg::COUNT_MAX) res.removed = res.removed + 1'b1;
          end
        end
        res.status = lt_pkg::ST_COUNT;
      end
      lt_pkg::FN_FIND: begin
        // Find reports an entry even after it has expired.
        if (hit >= 0) begin
          res.status = lt_pkg::ST_FOUND;
          res.cur_holder = slot_holder[hit];
          res.expiry = slot_expiry[hit];
          res.address = slot_addr[hit];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_req(input logic [lt_pkg::FUNC_W-1:0] f,
                           input logic [lt_pkg::KEY_W-1:0] k,
                           input logic [lt_pkg::KEY_W-1:0] h,
                           input logic [lt_pkg::TTL_W-1:0] t,
                           input logic [lt_pkg::TIME_W-1:0] a,
                           input logic [lt_pkg::TIME_W-1:0] n);
    lease_req_t r;
    r = '{func: f, lease_key: k, holder: h, ttl: t, addr: a, now_ms: n};
    pending_reqs.push_back(r);
  endtask

  // Builds one random request. Most use the pools and a slowly running clock;
  // a few carry full-width values so that every input bit toggles.
  task automatic queue_random_req();
    int unsigned roll;
    logic [lt_pkg::FUNC_W-1:0] f;
    logic [lt_pkg::KEY_W-1:0] k;
    logic [lt_pkg::KEY_W-1:0] h;
    logic [lt_pkg::TTL_W-1:0] t;
    logic [lt_pkg::TIME_W-1:0] a;
    logic [lt_pkg::TIME_W-1:0] n;
    roll = $urandom_range(99);
    if (roll < 45) f = lt_pkg::FN_ACQUIRE;
    else if (roll < 60) f = lt_pkg::FN_RELEASE;
    else if (roll < 67) f = lt_pkg::FN_PRUNE;
    else if (roll < 73) f = lt_pkg::FN_DROP;
    else if (roll < 95) f = lt_pkg::FN_FIND;
    else f = lt_pkg::FUNC_W'($urandom_range(5, 7));
    sim_now = sim_now + $urandom_range(0, 40);
    k = key_pool[$urandom_range(KEY_POOL - 1)];
    h = holder_pool[$urandom_range(3)];
    a = addr_pool[$urandom_range(3)];
    t = $urandom_range(0, 300);
    n = sim_now;
    roll = $urandom_range(99);
    if (roll < 4) k = {$urandom, $urandom};
    else if (roll < 8) h = {$urandom, $urandom};
    else if (roll < 12) a = lt_pkg::TIME_W'({$urandom, $urandom});
    else if (roll < 16) t = $urandom;
    else if (roll < 18) n = lt_pkg::TIME_W'({$urandom, $urandom});
    else if (roll < 20) n = TIME_MAX - $urandom_range(0, 500);
    queue_req(f, k, h, t, a, n);
  endtask

  // Sender: presents the next request, holds it while stalled, and records
  // the predicted answer on every accepted transfer.
  lease_req_t drive_req;
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i <= '0;
      lease_key_i <= '0;
      holder_i <= '0;
      ttl_i <= '0;
      holder_address_i <= '0;
      now_ms_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_answers.push_back(predict_lease(drive_req));
        sent_count <= sent_count + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drive_req = pending_reqs.pop_front();
          func_i <= drive_req.func;
          lease_key_i <= drive_req.lease_key;
          holder_i <= drive_req.holder;
          ttl_i <= drive_req.ttl;
          holder_address_i <= drive_req.addr;
          now_ms_i <= drive_req.now_ms;
          in_valid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every accepted answer against the
  // oldest prediction.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    lease_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        answer_count <= answer_count + 1;
        status_seen[status_o] <= status_seen[status_o] + 1;
        if (expected_answers.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("ERROR @%0d: answer status %0d with no request outstanding",
                     cycle_count, status_o);
        end else begin
          want = expected_answers.pop_front();
          if (status_o !== want.status || current_holder_o !== want.cur_holder ||
              remaining_ms_o !== want.remaining || entry_expiry_o !== want.expiry ||
              entry_address_o !== want.address || removed_count_o !== want.removed) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("ERROR @%0d: expected st=%0d hold=%h rem=%h exp=%h addr=%h cnt=%0d",
                       cycle_count, want.status, want.cur_holder, want.remaining,
                       want.expiry, want.address, want.removed);
              $display("              actual st=%0d hold=%h rem=%h exp=%h addr=%h cnt=%0d",
                       status_o, current_holder_o, remaining_ms_o, entry_expiry_o,
                       entry_address_o, removed_count_o);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // Cycle counter: switches calm stretches on and off and stops a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 400 == 399) calm <= ~calm;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d answers outstanding",
               cycle_count, expected_answers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    foreach (holder_pool[i]) holder_pool[i] = {$urandom, $urandom};
    holder_pool[0] = '0;
    foreach (addr_pool[i]) addr_pool[i] = lt_pkg::TIME_W'({$urandom, $urandom});
    addr_pool[1] = '1;
    sim_now = 48'd1000;

    // Directed part. Fill every entry, then one more new key finds the table full.
    for (int i = 0; i < NSLOT; i++)
      queue_req(lt_pkg::FN_ACQUIRE, key_pool[i], holder_pool[0], 100, addr_pool[i % 4], 1000);
    queue_req(lt_pkg::FN_ACQUIRE, key_pool[NSLOT], holder_pool[1], 100, addr_pool[0], 1000);
    // A live lease rejects a stranger, its owner renews it.
    queue_req(lt_pkg::FN_ACQUIRE, key_pool[0], holder_pool[1], 50, addr_pool[2], 1010);
    queue_req(lt_pkg::FN_ACQUIRE, key_pool[0], holder_pool[0], 500, addr_pool[2], 1020);
    // Release only works for the owner; find then misses the released key.
    queue_req(lt_pkg::FN_RELEASE, key_pool[1], holder_pool[1], 0, '0, 1030);
    queue_req(lt_pkg::FN_RELEASE, key_pool[1], holder_pool[0], 0, '0, 1030);
    queue_req(lt_pkg::FN_FIND, key_pool[1], '0, 0, '0, 1040);
    // An expired lease is still found, then taken over by another holder.
    queue_req(lt_pkg::FN_FIND, key_pool[2], '0, 0, '0, 1200);
    queue_req(lt_pkg::FN_ACQUIRE, key_pool[2], holder_pool[1], 10, addr_pool[3], 1200);
    queue_req(lt_pkg::FN_DROP, '0, '0, 0, addr_pool[1], 1210);
    queue_req(lt_pkg::FN_PRUNE, '0, '0, 0, '0, 1300);
    queue_req('1, '1, '1, '1, '1, '1);
    // Expiry saturates at the largest time.
    queue_req(lt_pkg::FN_ACQUIRE, '1, '1, '1, '1, TIME_MAX - 5);
    queue_req(lt_pkg::FN_FIND, '1, '0, 0, '0, TIME_MAX - 5);
    queue_req(lt_pkg::FN_PRUNE, '0, '0, 0, '0, TIME_MAX);
    sim_now = 48'd2000;
    for (int i = 0; i < 1400; i++) queue_random_req();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
    // Let any stray answer show up before the verdict.
    repeat (60) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d answers in %0d cycles, %0d mismatches.",
             sent_count, answer_count, cycle_count, mismatch_count);
    $write("Answers by status: acq %0d renew %0d rej %0d rel %0d norel %0d found %0d ",
           status_seen[lt_pkg::ST_ACQUIRED], status_seen[lt_pkg::ST_RENEWED],
           status_seen[lt_pkg::ST_REJECTED], status_seen[lt_pkg::ST_RELEASED],
           status_seen[lt_pkg::ST_NOT_RELEASED], status_seen[lt_pkg::ST_FOUND]);
    $display("absent %0d count %0d full %0d", status_seen[lt_pkg::ST_ABSENT],
             status_seen[lt_pkg::ST_COUNT], status_seen[lt_pkg::ST_FULL]);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lt_pkg.sv
sv/lt_front.sv
sv/lt_back.sv
sv/lease_table_top.sv
bench/lease_table_top_tb.sv
